// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file artp_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("%m: check failed");

// Concurrent check that also holds through reset.
`define ASSERT_ALW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== design/artp_pkg.sv =====
// Types, codes and constants for the ACK retry pending table.
// No dependencies; used by every other file of the block but assert_macros.svh.
package artp_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int MAX_RES    = 8;
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
  localparam int SLOT_W     = 3;
  localparam int REQ_W      = 2;
  localparam int EV_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;
  localparam int ADDR_W     = 8;
  localparam int KIND_W     = 8;
  localparam int SEQ_W      = 8;
  localparam int TMO_W      = 16;
  localparam int RETRY_W    = 4;
  localparam int LOST_W     = 32;

  localparam logic [ADDR_W-1:0]  BCAST_RST   = 8'd255;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd2000;
  localparam logic [RETRY_W-1:0] RETRY_RST   = 4'd3;

  typedef enum logic [EV_W-1:0] {
    EV_QUEUED      = 3'd0,
    EV_FULL        = 3'd1,
    EV_ACK_MATCHED = 3'd2,
    EV_ACK_IGNORED = 3'd3,
    EV_SEND_OK     = 3'd4,
    EV_RETRANSMIT  = 3'd5,
    EV_FAILED      = 3'd6,
    EV_IDLE        = 3'd7
  } event_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IS_GATEWAY  = 3'd0,
    CFG_OWN_ADDR    = 3'd1,
    CFG_BCAST_ADDR  = 3'd2,
    CFG_DATA_KIND   = 3'd3,
    CFG_ACK_TIMEOUT = 3'd4,
    CFG_RETRY_LIMIT = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_PRIME,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic                is_gateway;
    logic [ADDR_W-1:0]   own_address;
    logic [ADDR_W-1:0]   broadcast_address;
    logic [KIND_W-1:0]   data_kind_code;
    logic [TMO_W-1:0]    ack_timeout_ms;
    logic [RETRY_W-1:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest;
    logic [KIND_W-1:0]  kind;
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  stamp;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  typedef struct packed {
    event_t             ev;
    logic [SLOT_W-1:0]  slot;
    logic [SEQ_W-1:0]   seq;
    logic [ADDR_W-1:0]  peer;
    logic [KIND_W-1:0]  kind;
    logic [RETRY_W-1:0] retries;
    logic               ack_needed;
    logic [LOST_W-1:0]  lost;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic idx_inc;
    logic rd_en;
    logic add_step;
    logic scan_step;
    logic flush;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_push;
    logic out_free;
    logic add_stop;
    logic scan_stop;
  } dp_status_t;

endpackage

// ===== design/artp_chan_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
// Depends on artp_pkg for field widths.
interface artp_in_if;
  logic                          valid;
  logic                          ready;
  logic [artp_pkg::REQ_W-1:0]    req_type;
  logic [artp_pkg::TIME_W-1:0]   now_ms;
  logic [artp_pkg::ADDR_W-1:0]   dest_addr;
  logic [artp_pkg::KIND_W-1:0]   packet_kind;
  logic [artp_pkg::SEQ_W-1:0]    ack_seq;
  logic [artp_pkg::ADDR_W-1:0]   ack_source;

  modport source (output valid, req_type, now_ms, dest_addr, packet_kind, ack_seq,
                  ack_source, input ready);
  modport sink   (input valid, req_type, now_ms, dest_addr, packet_kind, ack_seq,
                  ack_source, output ready);
endinterface

interface artp_out_if;
  logic                           valid;
  logic                           ready;
  logic [artp_pkg::EV_W-1:0]      event_res;
  logic [artp_pkg::SLOT_W-1:0]    slot;
  logic [artp_pkg::SEQ_W-1:0]     seq_out;
  logic [artp_pkg::ADDR_W-1:0]    peer_addr;
  logic [artp_pkg::KIND_W-1:0]    kind_out;
  logic [artp_pkg::RETRY_W-1:0]   retry_count;
  logic                           ack_needed;
  logic [artp_pkg::LOST_W-1:0]    lost_total;
  logic                           last;

  modport source (output valid, event_res, slot, seq_out, peer_addr, kind_out,
                  retry_count, ack_needed, lost_total, last, input ready);
  modport sink   (input valid, event_res, slot, seq_out, peer_addr, kind_out,
                  retry_count, ack_needed, lost_total, last, output ready);
endinterface

// ===== design/artp_regs.sv =====
// Configuration register file: plain write port, no read-back.
// Depends on artp_pkg.
module artp_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [artp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [artp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output artp_pkg::cfg_t                     cfg
);
  import artp_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_IS_GATEWAY:  cfg_nxt.is_gateway        = cfg_wdata[0];
        CFG_OWN_ADDR:    cfg_nxt.own_address       = cfg_wdata[ADDR_W-1:0];
        CFG_BCAST_ADDR:  cfg_nxt.broadcast_address = cfg_wdata[ADDR_W-1:0];
        CFG_DATA_KIND:   cfg_nxt.data_kind_code    = cfg_wdata[KIND_W-1:0];
        CFG_ACK_TIMEOUT: cfg_nxt.ack_timeout_ms    = cfg_wdata[TMO_W-1:0];
        CFG_RETRY_LIMIT: cfg_nxt.retry_limit       = cfg_wdata[RETRY_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.is_gateway        <= 1'b0;
      cfg_r.own_address       <= '0;
      cfg_r.broadcast_address <= BCAST_RST;
      cfg_r.data_kind_code    <= '0;
      cfg_r.ack_timeout_ms    <= TIMEOUT_RST;
      cfg_r.retry_limit       <= RETRY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/artp_dp.sv =====
// Datapath: request latch, entry memory, valid bits, counters and the
// hold / output result registers. Depends on artp_pkg.
module artp_dp #(
  parameter int SLOTS = artp_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  artp_pkg::cfg_t                     cfg,
  input  artp_pkg::ctrl_cmd_t                cmd,
  output artp_pkg::dp_status_t               status,
  input  logic [artp_pkg::REQ_W-1:0]         in_req_type,
  input  logic [artp_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [artp_pkg::ADDR_W-1:0]        in_dest_addr,
  input  logic [artp_pkg::KIND_W-1:0]        in_packet_kind,
  input  logic [artp_pkg::SEQ_W-1:0]         in_ack_seq,
  input  logic [artp_pkg::ADDR_W-1:0]        in_ack_source,
  input  logic                               out_ready,
  output logic                               out_valid,
  output artp_pkg::result_t                  out_res,
  output logic                               out_last
);
  import artp_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  // latched request
  req_t               req_r;
  logic [TIME_W-1:0]  now_r;
  logic [ADDR_W-1:0]  dest_r;
  logic [KIND_W-1:0]  kind_r;
  logic [SEQ_W-1:0]   aseq_r;
  logic [ADDR_W-1:0]  asrc_r;

  logic [IW-1:0]        idx_r, idx_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [LOST_W-1:0]    loss_r, loss_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;

  entry_t mem [SLOTS];
  entry_t rd_q;
  logic   mem_we;
  entry_t mem_wd;
  logic [IW-1:0] rd_addr;

  logic    hold_valid_r, hold_valid_nxt;
  result_t hold_r, hold_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;
  logic    out_last_r, out_last_nxt;

  logic          idx_last, slot_free, cur_valid, out_free, can_push;
  logic          ack_for_us, timed_out;
  logic [TIME_W-1:0] age;
  logic          push;
  result_t       new_res, dflt_res;
  logic [SLOT_W-1:0] slot_id;

  assign idx_last  = (idx_r == IDX_LAST);
  assign cur_valid = valid_r[idx_r];
  assign slot_free = !cur_valid;
  assign out_free  = !out_valid_r || out_ready;
  assign can_push  = !hold_valid_r || out_free;
  assign slot_id   = SLOT_W'(idx_r);
  assign ack_for_us = (dest_r == cfg.own_address) || (dest_r == cfg.broadcast_address);
  assign age       = now_r - rd_q.stamp;
  assign timed_out = age > {{(TIME_W-TMO_W){1'b0}}, cfg.ack_timeout_ms};
  assign rd_addr   = cmd.idx_inc ? idx_r + 1'b1 : idx_r;

  // one add step or one scan step per cycle when the controller issues one, acting on slot idx_r
  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    loss_nxt  = loss_r;
    mem_we    = 1'b0;
    mem_wd    = rd_q;
    push      = 1'b0;
    new_res   = '0;
    new_res.ev = EV_IDLE;
    status.can_push  = can_push;
    status.out_free  = out_free;
    status.add_stop  = slot_free || idx_last;
    status.scan_stop = idx_last;

    if (cmd.add_step) begin
      if (slot_free) begin
        valid_nxt[idx_r] = 1'b1;
        mem_we         = 1'b1;
        mem_wd.dest    = dest_r;
        mem_wd.kind    = kind_r;
        mem_wd.seq     = seq_r;
        mem_wd.stamp   = now_r;
        mem_wd.retries = '0;
        seq_nxt        = seq_r + 1'b1;
        push           = 1'b1;
        new_res.ev     = EV_QUEUED;
        new_res.slot   = slot_id;
        new_res.seq    = seq_r;
        new_res.peer   = dest_r;
        new_res.kind   = kind_r;
        new_res.ack_needed = !cfg.is_gateway && (dest_r != cfg.broadcast_address);
      end else if (idx_last) begin
        push         = 1'b1;
        new_res.ev   = EV_FULL;
        new_res.peer = dest_r;
      end
    end

    if (cmd.scan_step && cur_valid) begin
      if (req_r == REQ_ACK) begin
        if (ack_for_us && rd_q.seq == aseq_r) begin
          valid_nxt[idx_r] = 1'b0;
          // beyond the result limit the slot is still freed, just not reported
          push            = (n_r < RES_CNT_W'(MAX_RES));
          new_res.ev      = EV_ACK_MATCHED;
          new_res.slot    = slot_id;
          new_res.seq     = aseq_r;
          new_res.peer    = asrc_r;
          new_res.kind    = rd_q.kind;
          new_res.retries = rd_q.retries;
        end
      end else begin
        new_res.slot    = slot_id;
        new_res.seq     = rd_q.seq;
        new_res.peer    = rd_q.dest;
        new_res.kind    = rd_q.kind;
        new_res.retries = rd_q.retries;
        if (cfg.is_gateway && rd_q.kind == cfg.data_kind_code) begin
          valid_nxt[idx_r] = 1'b0;
          push       = 1'b1;
          new_res.ev = EV_SEND_OK;
        end else if (rd_q.dest == cfg.broadcast_address) begin
          valid_nxt[idx_r] = 1'b0;
        end else if (timed_out) begin
          push = 1'b1;
          if (rd_q.retries < cfg.retry_limit) begin
            mem_we          = 1'b1;
            mem_wd.stamp    = now_r;
            mem_wd.retries  = rd_q.retries + 1'b1;
            new_res.ev      = EV_RETRANSMIT;
            new_res.retries = rd_q.retries + 1'b1;
          end else begin
            valid_nxt[idx_r] = 1'b0;
            loss_nxt   = loss_r + 1'b1;
            new_res.ev = EV_FAILED;
          end
        end
        // a tick ends after its last reportable result
        if (push && n_r == RES_CNT_W'(MAX_RES - 1)) status.scan_stop = 1'b1;
      end
    end
    new_res.lost = loss_nxt;
  end

  always_comb begin
    dflt_res      = '0;
    dflt_res.lost = loss_r;
    if (req_r == REQ_ACK) begin
      dflt_res.ev   = EV_ACK_IGNORED;
      dflt_res.seq  = aseq_r;
      dflt_res.peer = asrc_r;
    end else begin
      dflt_res.ev = EV_IDLE;
    end
  end

  // hold keeps the newest result until it is known whether more follow
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    n_nxt          = n_r;
    if (cmd.latch_in) n_nxt = '0;
    if (push) begin
      if (hold_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = hold_r;
        out_last_nxt  = 1'b0;
      end
      hold_valid_nxt = 1'b1;
      hold_nxt       = new_res;
      n_nxt          = n_r + 1'b1;
    end
    if (cmd.flush) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = hold_valid_r ? hold_r : dflt_res;
      out_last_nxt   = 1'b1;
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.latch_in)     idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      valid_r      <= '0;
      seq_r        <= '0;
      loss_r       <= '0;
      n_r          <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      valid_r      <= valid_nxt;
      seq_r        <= seq_nxt;
      loss_r       <= loss_nxt;
      n_r          <= n_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.latch_in) begin
      req_r  <= req_t'(in_req_type);
      now_r  <= in_now_ms;
      dest_r <= in_dest_addr;
      kind_r <= in_packet_kind;
      aseq_r <= in_ack_seq;
      asrc_r <= in_ack_source;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= mem_wd;
    if (cmd.rd_en) rd_q <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/artp_ctrl.sv =====
// Controller: accepts one request at a time and sequences the slot walk.
// Depends on artp_pkg.
module artp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [artp_pkg::REQ_W-1:0]   in_req_type,
  output logic                         in_ready,
  input  artp_pkg::dp_status_t         status,
  output artp_pkg::ctrl_cmd_t          cmd
);
  import artp_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (req_t'(in_req_type))
            REQ_ADD:           state_nxt = ST_ADD;
            REQ_ACK, REQ_TICK: state_nxt = ST_PRIME;
            REQ_NOP:           state_nxt = ST_FLUSH;
            default:           state_nxt = ST_FLUSH;
          endcase
        end
      end
      ST_ADD: begin
        if (status.can_push && status.add_stop) state_nxt = ST_FLUSH;
      end
      ST_PRIME: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.can_push && status.scan_stop) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_ADD: begin
        if (status.can_push) begin
          cmd.add_step = 1'b1;
          cmd.idx_inc  = !status.add_stop;
        end
      end
      ST_PRIME: cmd.rd_en = 1'b1;
      ST_SCAN: begin
        if (status.can_push) begin
          cmd.scan_step = 1'b1;
          cmd.idx_inc   = !status.scan_stop;
          cmd.rd_en     = !status.scan_stop;
        end
      end
      ST_FLUSH: cmd.flush = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== design/ack_retry_pending_table.sv =====
// ACK retry pending table: valid/ready request and result channels, config port.
// Beats on in_if: add (0), received ACK (1), tick (2), no-op (3). Each request
// yields one or more result beats on out_if; the final one carries last = 1.
// Config registers are to be written by the user through cfg_we / cfg_idx /
// cfg_wdata only while the block is idle; the block does not enforce this.
// Indexes beyond the register list are ignored. One request is worked at a
// time. An add walks the valid bits from slot 0 to the first free slot (all
// slots when full); an ACK or tick walks the slots through the entry memory's
// single registered read port, one slot a cycle when not paused, and a tick
// also stops at its MAX_RES-th result. Result beats pass through a hold
// register and an output register, so a new request is taken while the last
// beat of the previous one waits; if out_if stalls the walk pauses when both
// registers are occupied. Reset (rst_n low, synchronous) clears all valid
// bits, sequence number and loss counter and loads the config defaults; no
// clearing pass is needed, as entries are written only on add or retransmit.
module ack_retry_pending_table #(
  parameter int SLOTS = artp_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  artp_in_if.sink                            in_if,
  artp_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [artp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [artp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import artp_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    out_res;
  logic       in_ready;

  artp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  artp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_req_type (in_if.req_type),
    .in_ready    (in_ready),
    .status      (status),
    .cmd         (cmd)
  );

  artp_dp #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .in_req_type    (in_if.req_type),
    .in_now_ms      (in_if.now_ms),
    .in_dest_addr   (in_if.dest_addr),
    .in_packet_kind (in_if.packet_kind),
    .in_ack_seq     (in_if.ack_seq),
    .in_ack_source  (in_if.ack_source),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_res        (out_res),
    .out_last       (out_if.last)
  );

  assign in_if.ready        = in_ready;
  assign out_if.event_res   = out_res.ev;
  assign out_if.slot        = out_res.slot;
  assign out_if.seq_out     = out_res.seq;
  assign out_if.peer_addr   = out_res.peer;
  assign out_if.kind_out    = out_res.kind;
  assign out_if.retry_count = out_res.retries;
  assign out_if.ack_needed  = out_res.ack_needed;
  assign out_if.lost_total  = out_res.lost;

endmodule

// ===== design/artp_checker.sv =====
// Port-level checks for ack_retry_pending_table, attached by bind.
// Depends on artp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module artp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [artp_pkg::EV_W-1:0]    out_event,
  input logic                         out_ack_needed,
  input logic                         out_last
);
  import artp_pkg::*;

  logic single_beat_ev;

  // these events are always the only beat of their request
  assign single_beat_ev = (out_event == EV_QUEUED) || (out_event == EV_FULL) ||
                          (out_event == EV_ACK_IGNORED) || (out_event == EV_IDLE);

  // results still owed block the next request
  `ASSERT_RST(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready)

  `ASSERT_ALW(a_reset_empties_out, clk, !rst_n |=> !out_valid)

  `ASSERT_RST(a_single_beat_events, clk, rst_n, out_valid && single_beat_ev |-> out_last)

  `ASSERT_RST(a_ack_needed_only_queued, clk, rst_n, out_valid && out_ack_needed |-> out_event == EV_QUEUED)

  `ASSERT_RST(a_out_held, clk, rst_n, out_valid && !out_ready |=> out_valid)

endmodule

bind ack_retry_pending_table artp_checker u_artp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_event      (out_if.event_res),
  .out_ack_needed (out_if.ack_needed),
  .out_last       (out_if.last)
);

// ===== tb/sv/ack_retry_pending_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ack_retry_pending_table: a directed table and
// random request mixes under several register settings.
// Depends on artp_pkg, the artp_in_if / artp_out_if interfaces and the block's RTL.
module ack_retry_pending_table_tb;
  import artp_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int SETTLE      = SLOTS + 8;
  localparam int PHASE_ITEMS = 56;

  typedef struct packed {
    req_t               req;
    logic [TIME_W-1:0]  now;
    logic [ADDR_W-1:0]  dest;
    logic [KIND_W-1:0]  kind;
    logic [SEQ_W-1:0]   aseq;
    logic [ADDR_W-1:0]  asrc;
  } req_beat_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } out_beat_t;

  typedef struct {
    req_beat_t b;
    bit        typed;
    result_t   want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  artp_in_if  in_if();
  artp_out_if out_if();

  ack_retry_pending_table #(.SLOTS(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // table model
  cfg_t               tbl_cfg;
  logic               tbl_valid [SLOTS];
  entry_t             tbl_ent   [SLOTS];
  logic [SEQ_W-1:0]   tbl_next_seq;
  logic [LOST_W-1:0]  tbl_lost;

  out_beat_t          want_beats [$];
  dir_row_t           dir_rows   [$];
  int                 mismatches = 0;
  bit                 tx_burst = 1'b0;
  bit                 rx_burst = 1'b0;
  int                 rx_hold = 0;
  logic [TIME_W-1:0]  ms_now;

  function automatic result_t make_result(event_t ev, int sl, logic [SEQ_W-1:0] sq,
                                          logic [ADDR_W-1:0] peer, logic [KIND_W-1:0] kind,
                                          logic [RETRY_W-1:0] rc, logic need);
    result_t r;
    r.ev         = ev;
    r.slot       = SLOT_W'(sl);
    r.seq        = sq;
    r.peer       = peer;
    r.kind       = kind;
    r.retries    = rc;
    r.ack_needed = need;
    r.lost       = tbl_lost;
    return r;
  endfunction

  function automatic req_beat_t mk_req(req_t q, logic [TIME_W-1:0] now,
                                       logic [ADDR_W-1:0] dest, logic [KIND_W-1:0] kind,
                                       logic [SEQ_W-1:0] aseq, logic [ADDR_W-1:0] asrc);
    req_beat_t b;
    b.req  = q;
    b.now  = now;
    b.dest = dest;
    b.kind = kind;
    b.aseq = aseq;
    b.asrc = asrc;
    return b;
  endfunction

  function automatic void add_row(req_beat_t b, bit typed, result_t want);
    dir_row_t r;
    r.b     = b;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // Applies one accepted request to the table model and queues the result beats.
  function automatic void advance_table(req_beat_t b);
    result_t            batch [$];
    logic [TIME_W-1:0]  age;
    int                 free_slot;
    out_beat_t          ob;
    free_slot = -1;
    case (b.req)
      REQ_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (!tbl_valid[i] && free_slot < 0) free_slot = i;
        if (free_slot >= 0) begin
          tbl_valid[free_slot]         = 1'b1;
          tbl_ent[free_slot].dest      = b.dest;
          tbl_ent[free_slot].kind      = b.kind;
          tbl_ent[free_slot].seq       = tbl_next_seq;
          tbl_ent[free_slot].stamp     = b.now;
          tbl_ent[free_slot].retries   = '0;
          batch.push_back(make_result(EV_QUEUED, free_slot, tbl_next_seq, b.dest, b.kind, '0,
                          !tbl_cfg.is_gateway && b.dest != tbl_cfg.broadcast_address));
          tbl_next_seq = tbl_next_seq + 1'b1;
        end else begin
          batch.push_back(make_result(EV_FULL, 0, '0, b.dest, '0, '0, 1'b0));
        end
      end
      REQ_ACK: begin
        if (b.dest == tbl_cfg.own_address || b.dest == tbl_cfg.broadcast_address) begin
          // every matching slot is freed, only the first MAX_RES are reported
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_ent[i].seq == b.aseq) begin
              tbl_valid[i] = 1'b0;
              if (batch.size() < MAX_RES)
                batch.push_back(make_result(EV_ACK_MATCHED, i, b.aseq, b.asrc, tbl_ent[i].kind,
                                            tbl_ent[i].retries, 1'b0));
            end
          end
        end
        if (batch.size() == 0)
          batch.push_back(make_result(EV_ACK_IGNORED, 0, b.aseq, b.asrc, '0, '0, 1'b0));
      end
      REQ_TICK: begin
        for (int i = 0; i < SLOTS && batch.size() < MAX_RES; i++) begin
          if (tbl_valid[i]) begin
            age = b.now - tbl_ent[i].stamp;
            if (tbl_cfg.is_gateway && tbl_ent[i].kind == tbl_cfg.data_kind_code) begin
              tbl_valid[i] = 1'b0;
              batch.push_back(make_result(EV_SEND_OK, i, tbl_ent[i].seq, tbl_ent[i].dest,
                                          tbl_ent[i].kind, tbl_ent[i].retries, 1'b0));
            end else if (tbl_ent[i].dest == tbl_cfg.broadcast_address) begin
              tbl_valid[i] = 1'b0;  // dropped, no beat
            end else if (age > TIME_W'(tbl_cfg.ack_timeout_ms)) begin
              if (tbl_ent[i].retries < tbl_cfg.retry_limit) begin
                tbl_ent[i].stamp   = b.now;
                tbl_ent[i].retries = tbl_ent[i].retries + 1'b1;
                batch.push_back(make_result(EV_RETRANSMIT, i, tbl_ent[i].seq, tbl_ent[i].dest,
                                            tbl_ent[i].kind, tbl_ent[i].retries, 1'b0));
              end else begin
                tbl_valid[i] = 1'b0;
                tbl_lost     = tbl_lost + 1'b1;
                batch.push_back(make_result(EV_FAILED, i, tbl_ent[i].seq, tbl_ent[i].dest,
                                            tbl_ent[i].kind, tbl_ent[i].retries, 1'b0));
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (batch.size() == 0)
      batch.push_back(make_result(EV_IDLE, 0, '0, '0, '0, '0, 1'b0));
    foreach (batch[k]) begin
      ob.res  = batch[k];
      ob.last = (k == batch.size() - 1);
      want_beats.push_back(ob);
    end
  endfunction

  function automatic req_beat_t rand_req();
    req_beat_t b;
    int        pick;
    int        live [$];
    pick   = $urandom_range(0, 99);
    ms_now = ms_now + $urandom_range(0, tbl_cfg.ack_timeout_ms / 3 + 2);
    b.now  = ($urandom_range(0, 99) < 6) ? $urandom() : ms_now;
    b.dest = ADDR_W'($urandom());
    b.kind = KIND_W'($urandom());
    b.aseq = SEQ_W'($urandom());
    b.asrc = ADDR_W'($urandom());
    if (pick < 42) begin
      b.req = REQ_ADD;
      if ($urandom_range(0, 3) == 0) b.dest = tbl_cfg.broadcast_address;
      if ($urandom_range(0, 2) == 0) b.kind = tbl_cfg.data_kind_code;
    end else if (pick < 67) begin
      b.req = REQ_ACK;
      pick  = $urandom_range(0, 9);
      if (pick < 5) b.dest = tbl_cfg.own_address;
      else if (pick < 7) b.dest = tbl_cfg.broadcast_address;
      for (int i = 0; i < SLOTS; i++)
        if (tbl_valid[i]) live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 9) < 7)
        b.aseq = tbl_ent[live[$urandom_range(0, live.size() - 1)]].seq;
    end else if (pick < 95) begin
      b.req = REQ_TICK;
    end else begin
      b.req = REQ_NOP;
    end
    return b;
  endfunction

  task automatic send_req(req_beat_t b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= b.req;
    in_if.now_ms      <= b.now;
    in_if.dest_addr   <= b.dest;
    in_if.packet_kind <= b.kind;
    in_if.ack_seq     <= b.aseq;
    in_if.ack_source  <= b.asrc;
    do @(posedge clk); while (!in_if.ready);
    advance_table(b);
  endtask

  // Caller returns here in the step of the last accept, so valid drops right away.
  task automatic wait_results(bit settle);
    in_if.valid <= 1'b0;
    while (want_beats.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    cfg_idx_t              ix;
    logic [CFG_DATA_W-1:0] d;
    ix = ix.first();
    do begin
      case (ix)
        CFG_IS_GATEWAY:  d = CFG_DATA_W'(c.is_gateway);
        CFG_OWN_ADDR:    d = CFG_DATA_W'(c.own_address);
        CFG_BCAST_ADDR:  d = CFG_DATA_W'(c.broadcast_address);
        CFG_DATA_KIND:   d = CFG_DATA_W'(c.data_kind_code);
        CFG_ACK_TIMEOUT: d = CFG_DATA_W'(c.ack_timeout_ms);
        CFG_RETRY_LIMIT: d = CFG_DATA_W'(c.retry_limit);
        default:         d = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_idx   <= ix;
      cfg_wdata <= d;
      @(posedge clk);
      ix = ix.next();
    end while (ix != ix.first());
    cfg_we  <= 1'b0;
    tbl_cfg  = c;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls, compare each beat with the oldest expectation
  always @(posedge clk) begin : rx_side
    out_beat_t w;
    int        h;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (want_beats.size() == 0) begin
        $display("%0t ns: beat with nothing expected, expected none actual event %0d",
                 $time, out_if.event_res);
        mismatches++;
      end else begin
        w = want_beats.pop_front();
        check_field("event_res",   w.res.ev,         out_if.event_res);
        check_field("slot",        w.res.slot,       out_if.slot);
        check_field("seq_out",     w.res.seq,        out_if.seq_out);
        check_field("peer_addr",   w.res.peer,       out_if.peer_addr);
        check_field("kind_out",    w.res.kind,       out_if.kind_out);
        check_field("retry_count", w.res.retries,    out_if.retry_count);
        check_field("ack_needed",  w.res.ack_needed, out_if.ack_needed);
        check_field("lost_total",  w.res.lost,       out_if.lost_total);
        check_field("last",        w.last,           out_if.last);
      end
      h = rx_burst ? 0 : $urandom_range(0, 16);
      rx_hold      <= h;
      out_if.ready <= (h == 0);
    end else if (rx_hold != 0) begin
      rx_hold      <= rx_hold - 1;
      out_if.ready <= (rx_hold == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin : limit
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stim
    cfg_t plan [$];
    cfg_t c;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.req_type    <= REQ_NOP;
    in_if.now_ms      <= '0;
    in_if.dest_addr   <= '0;
    in_if.packet_kind <= '0;
    in_if.ack_seq     <= '0;
    in_if.ack_source  <= '0;

    tbl_cfg = '{is_gateway: 1'b0, own_address: '0, broadcast_address: BCAST_RST,
                data_kind_code: '0, ack_timeout_ms: TIMEOUT_RST, retry_limit: RETRY_RST};
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    tbl_next_seq = '0;
    tbl_lost     = '0;

    // directed rows, reset register values
    add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0), 1,
            make_result(EV_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_NOP, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1,
            make_result(EV_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_ACK, 0, 8'h00, 0, 8'h00, 8'h12), 1,
            make_result(EV_ACK_IGNORED, 0, 8'h00, 8'h12, 0, 0, 0));
    add_row(mk_req(REQ_ADD, 100, 8'h00, 8'h00, 0, 0), 1,
            make_result(EV_QUEUED, 0, 8'd0, 8'h00, 8'h00, 0, 1));
    add_row(mk_req(REQ_ADD, 100, 8'hFF, 8'hFF, 0, 0), 1,
            make_result(EV_QUEUED, 1, 8'd1, 8'hFF, 8'hFF, 0, 0));
    add_row(mk_req(REQ_ADD, 100, 8'h01, 8'h80, 0, 0), 1,
            make_result(EV_QUEUED, 2, 8'd2, 8'h01, 8'h80, 0, 1));
    add_row(mk_req(REQ_ADD, 200, 8'hFE, 8'h7F, 0, 0), 0, '0);
    add_row(mk_req(REQ_ADD, 300, 8'h33, 8'h11, 0, 0), 0, '0);
    add_row(mk_req(REQ_ADD, 300, 8'h44, 8'h22, 0, 0), 0, '0);
    add_row(mk_req(REQ_ADD, 400, 8'h55, 8'h33, 0, 0), 0, '0);
    add_row(mk_req(REQ_ADD, 400, 8'h66, 8'h44, 0, 0), 0, '0);
    // table full: sequence number does not advance
    add_row(mk_req(REQ_ADD, 500, 8'hAB, 8'h99, 0, 0), 1,
            make_result(EV_FULL, 0, 0, 8'hAB, 0, 0, 0));
    // ACK for another node
    add_row(mk_req(REQ_ACK, 500, 8'h55, 0, 8'd3, 8'h01), 1,
            make_result(EV_ACK_IGNORED, 0, 8'd3, 8'h01, 0, 0, 0));
    add_row(mk_req(REQ_ACK, 600, 8'h00, 0, 8'd3, 8'hFE), 0, '0);
    add_row(mk_req(REQ_ACK, 600, 8'hFF, 0, 8'd4, 8'h33), 0, '0);
    // age equal to the timeout does not expire; one more ms does
    add_row(mk_req(REQ_TICK, 2100, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(REQ_TICK, 2101, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(REQ_TICK, 6000, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(REQ_TICK, 9000, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(REQ_TICK, 12000, 0, 0, 0, 0), 0, '0);
    // age measured across the 32-bit time wrap
    add_row(mk_req(REQ_ADD, 32'hFFFF_F000, 8'h77, 8'h55, 0, 0), 0, '0);
    add_row(mk_req(REQ_TICK, 32'h0000_0800, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(REQ_ACK, 32'h0000_0900, 8'h00, 0, 8'hFF, 8'h00), 0, '0);
    add_row(mk_req(REQ_TICK, 32'h0010_0000, 0, 0, 0, 0), 0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      send_req(dir_rows[k].b);
      if (dir_rows[k].typed) want_beats[want_beats.size() - 1].res = dir_rows[k].want;
    end

    plan.push_back('{is_gateway: 1'b0, own_address: 8'h21, broadcast_address: 8'hFF,
                     data_kind_code: 8'h00, ack_timeout_ms: 16'd1, retry_limit: 4'd0});
    plan.push_back('{is_gateway: 1'b1, own_address: 8'h00, broadcast_address: 8'h00,
                     data_kind_code: 8'hFF, ack_timeout_ms: 16'hFFFF, retry_limit: 4'd15});
    plan.push_back('{is_gateway: 1'b0, own_address: 8'hFF, broadcast_address: 8'h80,
                     data_kind_code: 8'h5A, ack_timeout_ms: 16'd300, retry_limit: 4'd2});
    plan.push_back('{is_gateway: 1'b1, own_address: 8'h7E, broadcast_address: 8'hFF,
                     data_kind_code: 8'h01, ack_timeout_ms: 16'd1000, retry_limit: 4'd15});
    plan.push_back('{is_gateway: 1'b0, own_address: 8'h03, broadcast_address: 8'h10,
                     data_kind_code: 8'h03, ack_timeout_ms: 16'hFFFF, retry_limit: 4'd0});
    c.is_gateway        = 1'($urandom());
    c.own_address       = ADDR_W'($urandom());
    c.broadcast_address = ADDR_W'($urandom());
    c.data_kind_code    = KIND_W'($urandom());
    c.ack_timeout_ms    = TMO_W'($urandom_range(1, 4000));
    c.retry_limit       = RETRY_W'($urandom_range(0, 15));
    plan.push_back(c);

    foreach (plan[p]) begin
      wait_results(1);
      set_config(plan[p]);
      ms_now = (p == 2) ? 32'hFFFF_F800 : $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        send_req(rand_req());
        if ($urandom_range(0, 49) == 0) wait_results(0);
      end
    end

    wait_results(1);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== ack_retry_pending_table.f =====
+incdir+design
design/artp_pkg.sv
design/artp_chan_if.sv
design/artp_regs.sv
design/artp_dp.sv
design/artp_ctrl.sv
design/ack_retry_pending_table.sv
design/artp_checker.sv
tb/sv/ack_retry_pending_table_tb.sv
